FILE: hdl/dqcp_pkg.sv
// Shared constants for the dotted-quad CIDR parser.
// Used by dotted_quad_cidr_parser and its port checker; depends on nothing.
package dqcp_pkg;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;

  localparam logic [13:0] MaxOctet     = 14'd255;
  localparam logic [13:0] MaxPrefix    = 14'd32;
  localparam logic [5:0]  FullPrefix   = 6'd32;
  localparam logic [2:0]  OctetDigits  = 3'd4;
  localparam logic [2:0]  PrefixDigits = 3'd3;
  localparam logic [1:0]  LastPart     = 2'd3;

  localparam logic AllowPrefixReset = 1'b1;

endpackage

FILE: hdl/dotted_quad_cidr_parser.sv
// Parses dotted-decimal IPv4 text with an optional /N prefix, one character per transfer.
// A NUL transfer passes the input register, then the result register, before its result shows.
// Throughput: one character per cycle, except while a NUL waits on a full, stalled result
// register. Reset (rst_ni low, asynchronous) empties both registers, returns the parser to the
// first octet and sets allow_prefix to 1.
// Depends on dqcp_pkg.
module dotted_quad_cidr_parser
  import dqcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] address_o,
  output logic [5:0]  prefix_len_o
);

  typedef enum logic [1:0] {
    PhOctet  = 2'd0,
    PhPrefix = 2'd1,
    PhError  = 2'd2
  } phase_e;

  logic        allow_q;
  logic        in_v_q;
  logic [7:0]  ch_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  part_q, part_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [13:0] pval_q, pval_d;
  logic [31:0] addr_q, addr_d;
  logic        out_v_q;
  logic        res_ok_q, res_ok_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [5:0]  res_pfx_q, res_pfx_d;

  logic        is_nul, is_digit, octet_ok, adv, take;
  logic [13:0] pval_next;
  logic [2:0]  dcnt_next;
  logic [31:0] addr_shift;

  assign is_nul   = (ch_q == ChNul);
  assign is_digit = (ch_q >= ChZero) && (ch_q <= ChNine);
  assign octet_ok = (dcnt_q != 3'd0) && (pval_q <= MaxOctet);
  // For '0' through '9' the low nibble is the digit value.
  assign pval_next  = {pval_q[10:0], 3'b000} + {pval_q[12:0], 1'b0} + {10'd0, ch_q[3:0]};
  assign dcnt_next  = dcnt_q + 3'd1;
  assign addr_shift = {addr_q[23:0], pval_q[7:0]};

  // A NUL can only move on when the result register is free or being emptied.
  assign adv  = in_v_q && (!is_nul || !out_v_q || !out_stall_i);
  assign take = !in_v_q || adv;
  assign in_stall_o = !take;

  always_comb begin
    phase_d    = phase_q;
    part_d     = part_q;
    dcnt_d     = dcnt_q;
    pval_d     = pval_q;
    addr_d     = addr_q;
    res_ok_d   = 1'b0;
    res_addr_d = 32'd0;
    res_pfx_d  = 6'd0;
    if (is_nul) begin
      case (phase_q)
        PhOctet: begin
          if (part_q == LastPart && octet_ok) begin
            res_ok_d   = 1'b1;
            res_addr_d = addr_shift;
            res_pfx_d  = FullPrefix;
          end
        end
        PhPrefix: begin
          if (dcnt_q != 3'd0 && pval_q <= MaxPrefix) begin
            res_ok_d   = 1'b1;
            res_addr_d = addr_q;
            res_pfx_d  = pval_q[5:0];
          end
        end
        default: begin
        end
      endcase
      phase_d = PhOctet;
      part_d  = 2'd0;
      dcnt_d  = 3'd0;
      pval_d  = 14'd0;
      addr_d  = 32'd0;
    end else begin
      case (phase_q)
        PhOctet: begin
          if (is_digit) begin
            if (dcnt_q >= OctetDigits) begin
              phase_d = PhError;
            end else begin
              pval_d = pval_next;
              dcnt_d = dcnt_next;
            end
          end else if (ch_q == ChDot) begin
            if (part_q == LastPart || !octet_ok) begin
              phase_d = PhError;
            end else begin
              addr_d = addr_shift;
              part_d = part_q + 2'd1;
              dcnt_d = 3'd0;
              pval_d = 14'd0;
            end
          end else if (ch_q == ChSlash) begin
            if (allow_q && part_q == LastPart && octet_ok) begin
              addr_d  = addr_shift;
              phase_d = PhPrefix;
              dcnt_d  = 3'd0;
              pval_d  = 14'd0;
            end else begin
              phase_d = PhError;
            end
          end else begin
            phase_d = PhError;
          end
        end
        PhPrefix: begin
          if (is_digit && dcnt_q < PrefixDigits) begin
            pval_d = pval_next;
            dcnt_d = dcnt_next;
          end else begin
            phase_d = PhError;
          end
        end
        default: begin
          phase_d = PhError;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= AllowPrefixReset;
      in_v_q  <= 1'b0;
      phase_q <= PhOctet;
      part_q  <= 2'd0;
      dcnt_q  <= 3'd0;
      pval_q  <= 14'd0;
      addr_q  <= 32'd0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        allow_q <= cfg_wdata_i;
      end
      if (take) begin
        in_v_q <= in_valid_i;
      end
      if (adv) begin
        phase_q <= phase_d;
        part_q  <= part_d;
        dcnt_q  <= dcnt_d;
        pval_q  <= pval_d;
        addr_q  <= addr_d;
      end
      if (adv && is_nul) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q <= ch_i;
    end
    if (adv && is_nul) begin
      res_ok_q   <= res_ok_d;
      res_addr_q <= res_addr_d;
      res_pfx_q  <= res_pfx_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign valid_res_o  = res_ok_q;
  assign address_o    = res_addr_q;
  assign prefix_len_o = res_pfx_q;

endmodule

FILE: hdl/dqcp_checker.sv
// Port-level checks for dotted_quad_cidr_parser, attached by the bind below.
// Depends on dqcp_pkg.
module dqcp_checker
  import dqcp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        valid_res_o,
  input logic [31:0] address_o,
  input logic [5:0]  prefix_len_o
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(valid_res_o)
      && $stable(address_o) && $stable(prefix_len_o))
    else $error("stalled result changed");

  // A rejected text reports zero address and zero prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> address_o == 32'd0 && prefix_len_o == 6'd0)
    else $error("rejected result carries nonzero fields");

  // An accepted text never reports a prefix above the full length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> prefix_len_o <= FullPrefix)
    else $error("prefix length out of range");

  // With the result register empty, the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

endmodule

bind dotted_quad_cidr_parser dqcp_checker u_dqcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .valid_res_o  (valid_res_o),
  .address_o    (address_o),
  .prefix_len_o (prefix_len_o)
);
